### hw/rtl/kmh_pkg.sv
package kmh_pkg;

  localparam int SLOT_MAX   = 6;
  localparam int SLOT_W     = 3;
  localparam int TABLE_SIZE = 72;
  localparam int NIBBLE_W   = 4;
  localparam int ROW_IDX_W  = 4;
  localparam int POS_W      = ROW_IDX_W + 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_POLL   = 1'b1;

  // modifier key positions in the matrix
  localparam logic [ROW_IDX_W-1:0] RSHIFT_ROW = 4'd0;
  localparam logic [ROW_IDX_W-1:0] LEFT_MOD_ROW = 4'd7;

  typedef logic [7:0] usage_t;

  typedef struct packed {
    logic                 clear;
    logic                 load;
    logic [ROW_IDX_W-1:0] row;
    logic [7:0]           data;
  } kmh_bld_ctl_t;

  localparam usage_t USAGE_TABLE [TABLE_SIZE] = '{
    8'h41, 8'h28, 8'h2f, 8'h30, 8'h94, 8'he5, 8'h31, 8'h2a,
    8'h40, 8'hce, 8'h33, 8'h33, 8'h2d, 8'h38, 8'h2e, 8'h35,
    8'h3f, 8'h12, 8'h0f, 8'h0e, 8'h37, 8'h36, 8'h13, 8'h27,
    8'h3e, 8'h0c, 8'h18, 8'h0d, 8'h10, 8'h11, 8'h26, 8'h25,
    8'h3d, 8'h1c, 8'h0a, 8'h0b, 8'h05, 8'h19, 8'h24, 8'h23,
    8'h3c, 8'h17, 8'h15, 8'h07, 8'h09, 8'h06, 8'h22, 8'h21,
    8'h3b, 8'h1a, 8'h16, 8'h04, 8'h1b, 8'h1d, 8'h08, 8'h20,
    8'h3a, 8'h29, 8'h14, 8'he0, 8'he1, 8'he2, 8'h1e, 8'h1f,
    8'h4a, 8'h52, 8'h4f, 8'h50, 8'h51, 8'h2c, 8'h4c, 8'h49
  };

  function automatic logic in_table(input logic [POS_W-1:0] pos);
    return {1'b0, pos} < 8'(TABLE_SIZE);
  endfunction

  function automatic usage_t usage_code(input logic [POS_W-1:0] pos);
    usage_t code;
    code = 8'h00;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if ({1'b0, pos} == 8'(i)) begin
        code = USAGE_TABLE[i];
      end
    end
    return code;
  endfunction

endpackage

### hw/rtl/kmh_if.sv
interface kmh_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] row_index;
  logic [3:0] low_nibble;
  logic [3:0] high_nibble;

  modport source (output valid, cmd, row_index, low_nibble, high_nibble, input ready);
  modport sink   (input valid, cmd, row_index, low_nibble, high_nibble, output ready);
endinterface

interface kmh_out_if;
  logic       valid;
  logic       ready;
  logic       report_sent;
  logic [7:0] modifier;
  logic [7:0] key_slot0;
  logic [7:0] key_slot1;
  logic [7:0] key_slot2;
  logic [7:0] key_slot3;
  logic [7:0] key_slot4;
  logic [7:0] key_slot5;
  logic       change_pending;

  modport source (output valid, report_sent, modifier, key_slot0, key_slot1, key_slot2,
                  key_slot3, key_slot4, key_slot5, change_pending, input ready);
  modport sink   (input valid, report_sent, modifier, key_slot0, key_slot1, key_slot2,
                  key_slot3, key_slot4, key_slot5, change_pending, output ready);
endinterface

### hw/rtl/kmh_report_builder.sv
module kmh_report_builder #(
  parameter int KEYS_PER_REPORT = 6
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  kmh_pkg::kmh_bld_ctl_t                     ctl,
  output logic                                      busy,
  output logic [7:0]                                modifier,
  output logic [kmh_pkg::SLOT_MAX-1:0][7:0]         slots
);
  import kmh_pkg::*;

  logic [7:0]                  shift_r;
  logic [2:0]                  bit_r;
  logic                        busy_r;
  logic [ROW_IDX_W-1:0]        row_r;
  logic [SLOT_W-1:0]           count_r;
  logic [SLOT_MAX-1:0][7:0]    slots_r;
  logic [7:0]                  mod_r;
  logic [POS_W-1:0]            pos;
  logic                        take;

  assign pos  = {row_r, bit_r};
  assign take = busy_r && shift_r[0] && in_table(pos) && (count_r < SLOT_W'(KEYS_PER_REPORT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      slots_r <= '0;
      mod_r   <= '0;
    end else if (ctl.clear) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      slots_r <= '0;
      mod_r   <= '0;
    end else if (ctl.load) begin
      shift_r <= ctl.data;
      row_r   <= ctl.row;
      bit_r   <= '0;
      busy_r  <= 1'b1;
      if (ctl.row == RSHIFT_ROW) begin
        mod_r[5] <= mod_r[5] | ctl.data[5];
      end
      if (ctl.row == LEFT_MOD_ROW) begin
        mod_r[2:0] <= mod_r[2:0] | ctl.data[5:3];
      end
    end else if (busy_r) begin
      if (take) begin
        slots_r[count_r] <= usage_code(pos);
        count_r          <= count_r + 1'b1;
      end
      shift_r <= {1'b0, shift_r[7:1]};
      bit_r   <= bit_r + 1'b1;
      if (bit_r == 3'd7) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign modifier = mod_r;
  assign slots    = slots_r;

endmodule

### hw/rtl/keyboard_matrix_to_hid_report_top.sv
// row sample: result registered through the compare state, then the emit state
// ignored row or poll with no pending change: straight to the emit state, which registers the result
// poll with a pending change: per row one read, one load, a bit step in the report builder
//   for each bit of the row byte and one handover, then the emit state
// one item in flight; ready for the next transfer once the result registers, emit holds while one waits
// reset (rst_n low, synchronous) clears control and the valid bits, so both stores read zero
module keyboard_matrix_to_hid_report_top #(
  parameter int ROW_COUNT       = 9,
  parameter int KEYS_PER_REPORT = 6
) (
  input logic             clk,
  input logic             rst_n,
  kmh_in_if.sink          in_chan,
  kmh_out_if.source       out_chan
);
  import kmh_pkg::*;

  localparam int RW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SD  = 2 * ROW_COUNT;
  localparam int SAW = $clog2(SD);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SMP_CMP, ST_POLL_RD, ST_POLL_LD, ST_POLL_WAIT, ST_EMIT
  } state_t;

  state_t state_r;

  // control state
  logic          side_r;
  logic          flag_r;
  logic [RW-1:0] row_r;
  logic [7:0]    smp_byte_r;
  logic          smp_last_r;
  logic          sent_r;

  // result register
  logic                     out_valid_r;
  logic                     out_sent_r;
  logic                     out_pend_r;
  logic [7:0]               out_mod_r;
  logic [SLOT_MAX-1:0][7:0] out_slots_r;

  // two-sided row store, side s row r at s*ROW_COUNT + r
  logic [7:0]    smp_mem [SD];
  logic [SD-1:0] smp_vld_r;
  logic          smp_we;
  logic [SAW-1:0] smp_wr_addr;
  logic [7:0]    smp_wr_data;
  logic [SAW-1:0] smp_rd_addr;
  logic [7:0]    smp_rd_data_r;
  logic          smp_rd_vld_r;
  logic [7:0]    smp_q;

  // last reported copy
  logic [7:0]        rep_mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] rep_vld_r;
  logic              rep_we;
  logic [RW-1:0]     rep_rd_addr;
  logic [7:0]        rep_rd_data_r;
  logic              rep_rd_vld_r;
  logic [7:0]        rep_q;

  logic          in_fire;
  logic          in_sample_ok;
  logic [RW-1:0] in_row;

  kmh_bld_ctl_t             bld_ctl;
  logic                     bld_busy;
  logic [7:0]               bld_mod;
  logic [SLOT_MAX-1:0][7:0] bld_slots;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_row        = in_chan.row_index[RW-1:0];
  assign in_sample_ok  = (in_chan.cmd == CMD_SAMPLE) &&
                         ({1'b0, in_chan.row_index} < 5'(ROW_COUNT));

  // sample write goes to the active side, the other side is read alongside
  assign smp_we      = in_fire && in_sample_ok;
  assign smp_wr_addr = side_r ? (SAW'(ROW_COUNT) + SAW'(in_row)) : SAW'(in_row);
  assign smp_wr_data = {in_chan.high_nibble, in_chan.low_nibble};

  always_comb begin
    if (state_r == ST_IDLE) begin
      smp_rd_addr = side_r ? SAW'(in_row) : (SAW'(ROW_COUNT) + SAW'(in_row));
    end else begin
      smp_rd_addr = SAW'(row_r);
    end
  end

  assign smp_q = smp_rd_vld_r ? smp_rd_data_r : 8'h00;

  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[smp_wr_addr] <= smp_wr_data;
    end
    smp_rd_data_r <= smp_mem[smp_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r    <= '0;
      smp_rd_vld_r <= 1'b0;
    end else begin
      if (smp_we) begin
        smp_vld_r[smp_wr_addr] <= 1'b1;
      end
      smp_rd_vld_r <= smp_vld_r[smp_rd_addr];
    end
  end

  // reported copy is written from side 0 while a report is built
  assign rep_we      = (state_r == ST_POLL_LD);
  assign rep_rd_addr = in_row;
  assign rep_q       = rep_rd_vld_r ? rep_rd_data_r : 8'h00;

  always_ff @(posedge clk) begin
    if (rep_we) begin
      rep_mem[row_r] <= smp_q;
    end
    rep_rd_data_r <= rep_mem[rep_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_vld_r    <= '0;
      rep_rd_vld_r <= 1'b0;
    end else begin
      if (rep_we) begin
        rep_vld_r[row_r] <= 1'b1;
      end
      rep_rd_vld_r <= rep_vld_r[rep_rd_addr];
    end
  end

  // builder control
  always_comb begin
    bld_ctl       = '0;
    bld_ctl.clear = in_fire && (in_chan.cmd == CMD_POLL) && flag_r;
    bld_ctl.load  = (state_r == ST_POLL_LD);
    bld_ctl.row   = ROW_IDX_W'(row_r);
    bld_ctl.data  = smp_q;
  end

  kmh_report_builder #(
    .KEYS_PER_REPORT (KEYS_PER_REPORT)
  ) u_builder (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (bld_ctl),
    .busy     (bld_busy),
    .modifier (bld_mod),
    .slots    (bld_slots)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 1'b0;
      flag_r      <= 1'b0;
      row_r       <= '0;
      sent_r      <= 1'b0;
      smp_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the emit step handles its own handover
      if (out_valid_r && out_chan.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sent_r <= 1'b0;
            if (in_sample_ok) begin
              smp_byte_r <= smp_wr_data;
              smp_last_r <= (in_row == RW'(ROW_COUNT - 1));
              state_r    <= ST_SMP_CMP;
            end else if ((in_chan.cmd == CMD_POLL) && flag_r) begin
              row_r   <= '0;
              state_r <= ST_POLL_RD;
            end else begin
              // ignored row or poll with nothing new
              state_r <= ST_EMIT;
            end
          end
        end
        ST_SMP_CMP: begin
          // both sides agree and differ from what the host last saw
          if ((smp_byte_r == smp_q) && (smp_byte_r != rep_q)) begin
            flag_r <= 1'b1;
          end
          if (smp_last_r) begin
            side_r <= ~side_r;
          end
          state_r <= ST_EMIT;
        end
        ST_POLL_RD: begin
          state_r <= ST_POLL_LD;
        end
        ST_POLL_LD: begin
          state_r <= ST_POLL_WAIT;
        end
        ST_POLL_WAIT: begin
          if (!bld_busy) begin
            if (row_r == RW'(ROW_COUNT - 1)) begin
              flag_r  <= 1'b0;
              sent_r  <= 1'b1;
              state_r <= ST_EMIT;
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= ST_POLL_RD;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_sent_r  <= sent_r;
            out_pend_r  <= flag_r;
            out_mod_r   <= sent_r ? bld_mod : 8'h00;
            out_slots_r <= sent_r ? bld_slots : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.report_sent    = out_sent_r;
  assign out_chan.modifier       = out_mod_r;
  assign out_chan.key_slot0      = out_slots_r[0];
  assign out_chan.key_slot1      = out_slots_r[1];
  assign out_chan.key_slot2      = out_slots_r[2];
  assign out_chan.key_slot3      = out_slots_r[3];
  assign out_chan.key_slot4      = out_slots_r[4];
  assign out_chan.key_slot5      = out_slots_r[5];
  assign out_chan.change_pending = out_pend_r;

endmodule
